// ===== rtl/gb2312_text_to_font_rom_address_top_assert.svh =====
// assertion macros shared by the glyph address mapper
`ifndef GB2312_TEXT_TO_FONT_ROM_ADDRESS_TOP_ASSERT_SVH
`define GB2312_TEXT_TO_FONT_ROM_ADDRESS_TOP_ASSERT_SVH

// checked only outside reset
`define GBFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define GBFA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/gbfa_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfa_pkg
// Types and constants of the text to font ROM address mapper.
// ----------------------------------------------------------------------------
package gbfa_pkg;

   localparam int MAX_START_POS = 16;
   localparam int POS_W         = 5;
   localparam logic [POS_W-1:0] POS_SAT = '1;

   localparam logic [7:0]  HANZI_LO   = 8'hB0;
   localparam logic [7:0]  HANZI_HI   = 8'hF7;
   localparam logic [7:0]  SYMBOL_LO  = 8'hA1;
   localparam logic [7:0]  SYMBOL_HI  = 8'hA3;
   localparam logic [7:0]  TRAIL_LO   = 8'hA1;
   localparam logic [7:0]  ASCII_LO   = 8'h20;
   localparam logic [7:0]  ASCII_HI   = 8'h7E;
   localparam logic [6:0]  ROW_LEN    = 7'd94;
   localparam logic [12:0] HANZI_BASE = 13'd846;
   localparam logic [17:0] ASCII_BASE = 18'h3CF80;
   localparam logic [7:0]  WIDE_STEP  = 8'd16;
   localparam logic [7:0]  NARROW_STEP = 8'd8;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       string_start;
      logic [2:0] start_page;
      logic [7:0] start_column;
      logic       invert_video;
      logic [7:0] frame_mark;
   } gbfa_req_type;

   typedef struct packed {
      logic [7:0]       held_lead;
      logic             lead_pending;
      logic [POS_W-1:0] byte_position;
      logic [7:0]       current_column;
      logic [2:0]       current_page;
      logic             invert_flag;
      logic [7:0]       frame_bits;
      logic             string_active;
   } gbfa_state_type;

   typedef struct packed {
      logic [17:0] font_addr;
      logic        glyph_wide;
      logic [2:0]  glyph_page;
      logic [7:0]  glyph_column;
      logic        glyph_invert;
      logic [7:0]  glyph_frame;
   } gbfa_glyph_type;

endpackage

// ===== rtl/gbfa_decode.sv =====
// ----------------------------------------------------------------------------
// gbfa_decode
// Judges one text byte against the string state: next state and glyph command.
// ----------------------------------------------------------------------------
module gbfa_decode (
   input  gbfa_pkg::gbfa_req_type   req,
   input  gbfa_pkg::gbfa_state_type state,
   output gbfa_pkg::gbfa_state_type next_state,
   output logic                     emit,
   output gbfa_pkg::gbfa_glyph_type glyph
);
   import gbfa_pkg::*;

   gbfa_state_type   st;
   logic [7:0]       b;
   logic             is_lead;
   logic             is_print;
   logic             lead_hanzi;
   logic [6:0]       row;
   logic [6:0]       trail_off;
   logic [12:0]      idx;
   logic [6:0]       ascii_off;
   logic [POS_W-1:0] pos_inc;

   always_comb begin
      st = state;
      if (req.string_start) begin
         st.current_page   = req.start_page;
         st.current_column = req.start_column;
         st.invert_flag    = req.invert_video;
         st.frame_bits     = req.frame_mark;
         st.byte_position  = '0;
         st.lead_pending   = 1'b0;
         st.held_lead      = '0;
         st.string_active  = 1'b1;
      end
   end

   assign b        = req.text_byte;
   assign is_lead  = (b >= HANZI_LO && b <= HANZI_HI) || (b >= SYMBOL_LO && b <= SYMBOL_HI);
   assign is_print = (b >= ASCII_LO) && (b <= ASCII_HI);
   assign pos_inc  = (st.byte_position == POS_SAT) ? st.byte_position
                                                   : st.byte_position + 1'b1;

   // row and offset inside the code table
   assign lead_hanzi = st.held_lead >= HANZI_LO;
   assign row  = lead_hanzi ? 7'(st.held_lead - HANZI_LO) : 7'(st.held_lead - SYMBOL_LO);
   assign trail_off = 7'(b - TRAIL_LO);
   assign idx  = 13'(row) * 13'(ROW_LEN) + 13'(trail_off) +
                 (lead_hanzi ? HANZI_BASE : 13'd0);
   assign ascii_off = 7'(b - ASCII_LO);

   always_comb begin
      next_state = st;
      emit       = 1'b0;
      glyph.font_addr    = '0;
      glyph.glyph_wide   = 1'b0;
      glyph.glyph_page   = st.current_page;
      glyph.glyph_column = st.current_column;
      glyph.glyph_invert = st.invert_flag;
      glyph.glyph_frame  = st.frame_bits;
      if (st.string_active) begin
         if (st.lead_pending && b >= TRAIL_LO) begin
            next_state.lead_pending   = 1'b0;
            next_state.byte_position  = pos_inc;
            next_state.current_column = st.current_column + WIDE_STEP;
            emit             = 1'b1;
            glyph.glyph_wide = 1'b1;
            glyph.font_addr  = {idx, 5'd0};
         end else begin
            next_state.lead_pending = 1'b0;
            if (b == 8'd0 || st.byte_position >= POS_W'(MAX_START_POS)) begin
               next_state.string_active = 1'b0;
            end else begin
               next_state.byte_position = pos_inc;
               if (is_lead) begin
                  next_state.held_lead    = b;
                  next_state.lead_pending = 1'b1;
               end else if (is_print) begin
                  next_state.current_column = st.current_column + NARROW_STEP;
                  emit            = 1'b1;
                  glyph.font_addr = {7'd0, ascii_off, 4'd0} + ASCII_BASE;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/gbfa_outq.sv =====
// ----------------------------------------------------------------------------
// gbfa_outq
// Result register with a one-entry skid stage behind it.
// ----------------------------------------------------------------------------
module gbfa_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  gbfa_pkg::gbfa_glyph_type push_data,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output gbfa_pkg::gbfa_glyph_type rsp_data,
   output logic                     full
);
   import gbfa_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   gbfa_glyph_type out_data_ff, out_data_in;
   gbfa_glyph_type skid_data_ff, skid_data_in;
   logic           take;

   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!out_valid_ff || take) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

// ===== rtl/gb2312_text_to_font_rom_address_top.sv =====
// a glyph command is registered in the result register, or in the skid slot while the result is stalled
// throughput: one request per cycle while req_stall is low; the state update is a single registered pass
// a one-entry skid stage keeps requests flowing while a result is stalled
// req_stall rises only while both result slots are occupied
// reset (synchronous) clears the string state and empties the result slots
// ----------------------------------------------------------------------------
// gb2312_text_to_font_rom_address_top
// Maps an encoded text string to font ROM addresses and screen places.
// ----------------------------------------------------------------------------
`include "gb2312_text_to_font_rom_address_top_assert.svh"

module gb2312_text_to_font_rom_address_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_string_start,
   input  logic [2:0]  req_start_page,
   input  logic [7:0]  req_start_column,
   input  logic        req_invert_video,
   input  logic [7:0]  req_frame_mark,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [17:0] rsp_font_addr,
   output logic        rsp_glyph_wide,
   output logic [2:0]  rsp_glyph_page,
   output logic [7:0]  rsp_glyph_column,
   output logic        rsp_glyph_invert,
   output logic [7:0]  rsp_glyph_frame
);
   import gbfa_pkg::*;

   gbfa_req_type   req;
   gbfa_state_type state_ff, state_in, dec_next;
   gbfa_glyph_type dec_glyph, rsp_data;
   logic           dec_emit;
   logic           accept;
   logic           full;

   assign req.text_byte    = req_text_byte;
   assign req.string_start = req_string_start;
   assign req.start_page   = req_start_page;
   assign req.start_column = req_start_column;
   assign req.invert_video = req_invert_video;
   assign req.frame_mark   = req_frame_mark;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   gbfa_decode u_decode (
      .req        (req),
      .state      (state_ff),
      .next_state (dec_next),
      .emit       (dec_emit),
      .glyph      (dec_glyph)
   );

   assign state_in = accept ? dec_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   gbfa_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept && dec_emit),
      .push_data  (dec_glyph),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .full       (full)
   );

   assign rsp_font_addr    = rsp_data.font_addr;
   assign rsp_glyph_wide   = rsp_data.glyph_wide;
   assign rsp_glyph_page   = rsp_data.glyph_page;
   assign rsp_glyph_column = rsp_data.glyph_column;
   assign rsp_glyph_invert = rsp_data.glyph_invert;
   assign rsp_glyph_frame  = rsp_data.glyph_frame;

   // skid slot only fills behind an occupied result register
   `GBFA_ASSERT(a_skid_behind_out, full |-> rsp_valid, "skid slot full with result empty")
   // a held lead only exists inside an active string
   `GBFA_ASSERT(a_pending_active, state_ff.lead_pending |-> state_ff.string_active,
                "lead pending outside a string")
   `GBFA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !full,
                       "result slots not empty after reset")

endmodule

// ===== verif/gb2312_glyph_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_glyph_checker
// Watches the request and glyph channels of the font ROM address mapper,
// predicts the glyph command of every accepted request byte and compares
// each accepted glyph command field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gb2312_glyph_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_string_start,
   input  logic [2:0]  req_start_page,
   input  logic [7:0]  req_start_column,
   input  logic        req_invert_video,
   input  logic [7:0]  req_frame_mark,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [17:0] rsp_font_addr,
   input  logic        rsp_glyph_wide,
   input  logic [2:0]  rsp_glyph_page,
   input  logic [7:0]  rsp_glyph_column,
   input  logic        rsp_glyph_invert,
   input  logic [7:0]  rsp_glyph_frame,
   output int          fail_count,
   output int          glyph_backlog
);
   import gbfa_pkg::*;

   gbfa_state_type text_state;
   gbfa_glyph_type glyph_queue[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
      fail_count++;
   endtask

   task automatic bump_position();
      if (text_state.byte_position != POS_SAT)
         text_state.byte_position++;
   endtask

   task automatic push_glyph(input int unsigned addr, input logic wide);
      gbfa_glyph_type g;
      g.font_addr    = addr[17:0];
      g.glyph_wide   = wide;
      g.glyph_page   = text_state.current_page;
      g.glyph_column = text_state.current_column;
      g.glyph_invert = text_state.invert_flag;
      g.glyph_frame  = text_state.frame_bits;
      glyph_queue.push_back(g);
      text_state.current_column += wide ? WIDE_STEP : NARROW_STEP;
   endtask

   // one request byte through the string state
   task automatic map_text_byte(input gbfa_req_type r);
      int unsigned b;
      int unsigned lead;
      int unsigned idx;
      logic        paired;
      b = 32'(r.text_byte);
      paired = 1'b0;
      if (r.string_start) begin
         text_state.current_page   = r.start_page;
         text_state.current_column = r.start_column;
         text_state.invert_flag    = r.invert_video;
         text_state.frame_bits     = r.frame_mark;
         text_state.byte_position  = '0;
         text_state.lead_pending   = 1'b0;
         text_state.held_lead      = '0;
         text_state.string_active  = 1'b1;
      end
      if (text_state.string_active) begin
         if (text_state.lead_pending) begin
            text_state.lead_pending = 1'b0;
            if (b >= TRAIL_LO) begin
               lead = 32'(text_state.held_lead);
               if (lead >= HANZI_LO)
                  idx = (lead - HANZI_LO) * ROW_LEN + (b - TRAIL_LO) + HANZI_BASE;
               else
                  idx = (lead - SYMBOL_LO) * ROW_LEN + (b - TRAIL_LO);
               bump_position();
               push_glyph(idx * 32, 1'b1);
               paired = 1'b1;
            end
         end
         // a byte that is not a trail is judged on its own
         if (!paired) begin
            if (b == 0 || text_state.byte_position >= MAX_START_POS) begin
               text_state.string_active = 1'b0;
            end else begin
               bump_position();
               if ((b >= HANZI_LO && b <= HANZI_HI) || (b >= SYMBOL_LO && b <= SYMBOL_HI)) begin
                  text_state.held_lead    = b[7:0];
                  text_state.lead_pending = 1'b1;
               end else if (b >= ASCII_LO && b <= ASCII_HI) begin
                  push_glyph((b - ASCII_LO) * 16 + ASCII_BASE, 1'b0);
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      gbfa_glyph_type want;
      gbfa_req_type   r;
      if (reset) begin
         text_state = '0;
         glyph_queue.delete();
         fail_count = 0;
      end else begin
         // the glyph leaving now belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (glyph_queue.size() == 0) begin
               report_mismatch("glyph with none expected, font_addr", 32'(rsp_font_addr), 0);
            end else begin
               want = glyph_queue.pop_front();
               if (rsp_font_addr != want.font_addr)
                  report_mismatch("font_addr", 32'(rsp_font_addr), 32'(want.font_addr));
               if (rsp_glyph_wide != want.glyph_wide)
                  report_mismatch("glyph_wide", 32'(rsp_glyph_wide), 32'(want.glyph_wide));
               if (rsp_glyph_page != want.glyph_page)
                  report_mismatch("glyph_page", 32'(rsp_glyph_page), 32'(want.glyph_page));
               if (rsp_glyph_column != want.glyph_column)
                  report_mismatch("glyph_column", 32'(rsp_glyph_column),
                                  32'(want.glyph_column));
               if (rsp_glyph_invert != want.glyph_invert)
                  report_mismatch("glyph_invert", 32'(rsp_glyph_invert),
                                  32'(want.glyph_invert));
               if (rsp_glyph_frame != want.glyph_frame)
                  report_mismatch("glyph_frame", 32'(rsp_glyph_frame), 32'(want.glyph_frame));
            end
         end
         if (req_valid && !req_stall) begin
            r.text_byte    = req_text_byte;
            r.string_start = req_string_start;
            r.start_page   = req_start_page;
            r.start_column = req_start_column;
            r.invert_video = req_invert_video;
            r.frame_mark   = req_frame_mark;
            map_text_byte(r);
         end
      end
      glyph_backlog = glyph_queue.size();
   end

endmodule

// ===== verif/gb2312_text_to_font_rom_address_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_text_to_font_rom_address_top_tb
// Feeds encoded strings to the font ROM address mapper: a directed run over
// pairs, ASCII, skipped bytes and string restarts, then random strings under
// three idling patterns. The checker beside the block judges every glyph.
// ----------------------------------------------------------------------------
module gb2312_text_to_font_rom_address_top_tb;
   import gbfa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = '0;
   logic        req_string_start = 1'b0;
   logic [2:0]  req_start_page = '0;
   logic [7:0]  req_start_column = '0;
   logic        req_invert_video = 1'b0;
   logic [7:0]  req_frame_mark = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [17:0] rsp_font_addr;
   logic        rsp_glyph_wide;
   logic [2:0]  rsp_glyph_page;
   logic [7:0]  rsp_glyph_column;
   logic        rsp_glyph_invert;
   logic [7:0]  rsp_glyph_frame;

   int fail_count;
   int glyph_backlog;
   int cycle_count = 0;
   int sent_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   // placement of the string being sent
   logic       fresh_string = 1'b0;
   logic [2:0] str_page;
   logic [7:0] str_column;
   logic       str_invert;
   logic [7:0] str_frame;

   always #2 clock = ~clock;

   gb2312_text_to_font_rom_address_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_string_start (req_string_start),
      .req_start_page   (req_start_page),
      .req_start_column (req_start_column),
      .req_invert_video (req_invert_video),
      .req_frame_mark   (req_frame_mark),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_font_addr    (rsp_font_addr),
      .rsp_glyph_wide   (rsp_glyph_wide),
      .rsp_glyph_page   (rsp_glyph_page),
      .rsp_glyph_column (rsp_glyph_column),
      .rsp_glyph_invert (rsp_glyph_invert),
      .rsp_glyph_frame  (rsp_glyph_frame)
   );

   gb2312_glyph_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_string_start (req_string_start),
      .req_start_page   (req_start_page),
      .req_start_column (req_start_column),
      .req_invert_video (req_invert_video),
      .req_frame_mark   (req_frame_mark),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_font_addr    (rsp_font_addr),
      .rsp_glyph_wide   (rsp_glyph_wide),
      .rsp_glyph_page   (rsp_glyph_page),
      .rsp_glyph_column (rsp_glyph_column),
      .rsp_glyph_invert (rsp_glyph_invert),
      .rsp_glyph_frame  (rsp_glyph_frame),
      .fail_count       (fail_count),
      .glyph_backlog    (glyph_backlog)
   );

   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < rx_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic s, input logic [2:0] pg,
                            input logic [7:0] col, input logic inv, input logic [7:0] fr);
      logic stalled;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_text_byte    <= b;
      req_string_start <= s;
      req_start_page   <= pg;
      req_start_column <= col;
      req_invert_video <= inv;
      req_frame_mark   <= fr;
      // stall is settled by the falling edge
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      sent_count++;
   endtask

   // placement fields outside the first byte are noise the block must ignore
   task automatic put(input logic [7:0] b);
      if (fresh_string)
         send_byte(b, 1'b1, str_page, str_column, str_invert, str_frame);
      else
         send_byte(b, 1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
      fresh_string = 1'b0;
   endtask

   task automatic open_string(input logic [2:0] pg, input logic [7:0] col,
                              input logic inv, input logic [7:0] fr);
      str_page     = pg;
      str_column   = col;
      str_invert   = inv;
      str_frame    = fr;
      fresh_string = 1'b1;
   endtask

   task automatic put_char();
      int kind;
      kind = $urandom_range(9);
      if (kind < 4) begin
         put(8'($urandom_range(HANZI_HI, HANZI_LO)));
         put(8'($urandom_range(8'hFF, TRAIL_LO)));
      end else if (kind == 4) begin
         put(8'($urandom_range(SYMBOL_HI, SYMBOL_LO)));
         put(8'($urandom_range(8'hFF, TRAIL_LO)));
      end else if (kind < 9) begin
         put(8'($urandom_range(ASCII_HI, ASCII_LO)));
      end else begin
         // lead with no trail: the next byte stands alone
         put(8'($urandom_range(HANZI_HI, HANZI_LO)));
         put(8'($urandom_range(TRAIL_LO - 1, 1)));
      end
   endtask

   task automatic one_string();
      int shape;
      int n;
      shape = $urandom_range(9);
      open_string(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
      if (shape < 7) begin
         n = $urandom_range(12, 1);
         repeat (n) put_char();
         if ($urandom_range(4) != 0)
            put(8'h00);
      end else if (shape == 7) begin
         // run up to the start limit, pair straddling it, then bytes past it
         n = $urandom_range(MAX_START_POS, MAX_START_POS - 2);
         repeat (n) put(8'($urandom_range(ASCII_HI, ASCII_LO)));
         put(8'($urandom_range(HANZI_HI, HANZI_LO)));
         put(8'($urandom_range(8'hFF, TRAIL_LO)));
         repeat ($urandom_range(3, 1)) put(8'($urandom_range(ASCII_HI, ASCII_LO)));
      end else begin
         n = $urandom_range(10, 1);
         repeat (n)
            send_byte(8'($urandom), $urandom_range(9) == 0, 3'($urandom), 8'($urandom),
                      1'($urandom), 8'($urandom));
         fresh_string = 1'b0;
      end
   endtask

   task automatic wait_glyphs_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (glyph_backlog != 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle block ignores bytes without a string start
      send_byte("A", 1'b0, 3'd7, 8'hFF, 1'b1, 8'hFF);
      open_string(3'd7, 8'hFF, 1'b1, 8'hFF);
      put(ASCII_LO);
      put(ASCII_HI);                 // column wrapped with the byte before
      put(HANZI_LO);
      put(TRAIL_LO);
      put(HANZI_HI);
      put(8'hFF);
      put(SYMBOL_LO);
      put(TRAIL_LO);
      put(SYMBOL_HI);
      put(8'hFE);
      put(8'hB5);
      put("A");                      // lead dropped, byte stands alone
      put(8'h1F);
      put(8'h7F);
      put(8'h80);
      put(8'hC0);
      // restart while a lead is held
      open_string(3'd0, 8'h00, 1'b0, 8'h00);
      put(8'hA2);
      put(8'hA5);
      put(8'hD3);
      put(8'h00);                    // zero after a lead ends the string
      put("A");
      wait_glyphs_drained();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 88 : 0;
         rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 31 : 0;
         while (sent_count < 22 + 185 * (ph + 1))
            one_string();
         wait_glyphs_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gbfa_pkg.sv
rtl/gbfa_decode.sv
rtl/gbfa_outq.sv
rtl/gb2312_text_to_font_rom_address_top.sv
verif/gb2312_glyph_checker.sv
verif/gb2312_text_to_font_rom_address_top_tb.sv
